[rtl/crf_pkg.sv]
// Shared types and fixed field widths of the circle raster frame buffer.
`default_nettype none

package crf_pkg;

  // Fixed widths of the request and result fields
  localparam int ACTION_W   = 2;
  localparam int CENTER_W   = 12;
  localparam int RADIUS_W   = 5;
  localparam int ROW_SEL_W  = 5;
  localparam int ROW_BITS_W = 64;

  // Request action codes; the fourth code is ignored
  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_DRAW  = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture a draw request and its bounding box
    logic clear;     // blank the whole frame
    logic read_row;  // issue the store read for a read request
    logic col_step;  // square one column offset
    logic row_step;  // read one row of the box and square its row offset
    logic out_load;  // capture the row returned by a read request
  } crf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic col_last;   // column pass is at its last column
    logic box_empty;  // clipped box holds no pixel
    logic row_last;   // row pass is at the last row of the box
  } crf_status_t;

endpackage

`default_nettype wire

[rtl/crf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module crf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/crf_ctrl.sv]
// Controller state machine of the circle raster frame buffer.
`default_nettype none

module crf_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [crf_pkg::ACTION_W-1:0]  action_i,
  input  wire crf_pkg::crf_status_t          status_i,
  output crf_pkg::crf_cmd_t                  cmd_o,
  output logic                               busy_o,
  output logic                               done_o
);

  import crf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COLS,
    ST_ROWS,
    ST_DRAIN,
    ST_READ
  } state_e;

  state_e state_q, state_d;
  logic   done_q;
  logic   take;

  assign take = start_i && (state_q == ST_IDLE);

  // Decode commands for the datapath
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = take && (action_i == ACT_DRAW);
    cmd_o.clear    = take && (action_i == ACT_CLEAR);
    cmd_o.read_row = take && (action_i == ACT_READ);
    cmd_o.col_step = (state_q == ST_COLS) && !status_i.box_empty;
    cmd_o.row_step = (state_q == ST_ROWS);
    cmd_o.out_load = (state_q == ST_READ);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take && (action_i == ACT_DRAW)) begin
          state_d = ST_COLS;
        end else if (take && (action_i == ACT_READ)) begin
          state_d = ST_READ;
        end
      end
      ST_COLS: begin
        if (status_i.box_empty) begin
          state_d = ST_IDLE;
        end else if (status_i.col_last) begin
          state_d = ST_ROWS;
        end
      end
      ST_ROWS: begin
        if (status_i.row_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_IDLE;
      ST_READ:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Hold state and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_READ);
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

[rtl/crf_datapath.sv]
// Datapath: bounding box, distance squares, row update and frame store.
`default_nettype none

module crf_datapath #(
  parameter int FRAME_WIDTH  = 64,
  parameter int FRAME_HEIGHT = 32,
  parameter int FRAC_BITS    = 4
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire crf_pkg::crf_cmd_t                    cmd_i,
  input  wire logic signed [crf_pkg::CENTER_W-1:0]  center_x_i,
  input  wire logic signed [crf_pkg::CENTER_W-1:0]  center_y_i,
  input  wire logic [crf_pkg::RADIUS_W-1:0]         radius_i,
  input  wire logic [crf_pkg::ROW_SEL_W-1:0]        row_select_i,
  output crf_pkg::crf_status_t                      status_o,
  output logic [crf_pkg::ROW_BITS_W-1:0]            row_bits_o
);

  import crf_pkg::*;

  // Index widths
  localparam int AW  = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
  localparam int YCW = $clog2(FRAME_HEIGHT + 1);
  localparam int CCW = $clog2(FRAME_WIDTH);
  localparam int SW  = (ROW_SEL_W > YCW) ? ROW_SEL_W : YCW;

  // Box arithmetic widths
  localparam int RSW  = RADIUS_W + FRAC_BITS;
  localparam int MAXD = (FRAME_HEIGHT > FRAME_WIDTH) ? FRAME_HEIGHT : FRAME_WIDTH;
  localparam int LIMW = $clog2(MAXD * (2 ** FRAC_BITS)) + 1;
  localparam int BW0  = (CENTER_W > RSW + 1) ? CENTER_W : RSW + 1;
  localparam int BW   = ((BW0 > LIMW + 1) ? BW0 : LIMW + 1) + 1;
  localparam int EW   = BW - FRAC_BITS;
  localparam logic signed [BW-1:0] LIM_X = BW'(FRAME_WIDTH * (2 ** FRAC_BITS));
  localparam logic signed [BW-1:0] LIM_Y = BW'(FRAME_HEIGHT * (2 ** FRAC_BITS));

  // Distance widths
  localparam int PXW = CCW + FRAC_BITS;
  localparam int PYW = AW + FRAC_BITS;
  localparam int DXW = ((CENTER_W > PXW + 1) ? CENTER_W : PXW + 1) + 1;
  localparam int DYW = ((CENTER_W > PYW + 1) ? CENTER_W : PYW + 1) + 1;
  localparam int MXW = DXW - 1;
  localparam int MYW = DYW - 1;
  localparam int R2W = 2 * RSW;
  localparam int SQ0 = (2 * MXW > 2 * MYW) ? 2 * MXW : 2 * MYW;
  localparam int SUMW = ((SQ0 > R2W) ? SQ0 : R2W) + 1;

  // Clip [c - rs, c + rs] to [0, lim) and convert to pixel indexes
  function automatic void span(
    input  logic signed [BW-1:0] c,
    input  logic signed [BW-1:0] rs,
    input  logic signed [BW-1:0] lim,
    output logic [EW-1:0]        b,
    output logic [EW-1:0]        e
  );
    logic signed [BW-1:0] lo;
    logic signed [BW-1:0] hi;
    lo = c - rs;
    hi = c + rs;
    if (lo < 0) lo = '0;
    if (hi > lim) hi = lim;
    b = lo[BW-1:FRAC_BITS];
    e = (hi > 0) ? hi[BW-1:FRAC_BITS] : '0;
  endfunction

  // Request registers
  logic signed [CENTER_W-1:0] cx_q, cy_q;
  logic [R2W-1:0]             r2_q;
  logic [EW-1:0]              bx_q, ex_q;
  logic [YCW-1:0]             ey_q;
  logic                       empty_q;
  logic [CCW-1:0]             col_q;
  logic [YCW-1:0]             y_q;

  // Column lanes
  logic [2*MXW-1:0]           dx2_q [FRAME_WIDTH];
  logic [FRAME_WIDTH-1:0]     mask_q;

  // Row pipeline
  logic [2*MYW-1:0]           dy2_q;
  logic [AW-1:0]              y1_q;
  logic                       wr_pend_q;
  logic [FRAME_HEIGHT-1:0]    row_valid_q;

  // Read request
  logic [AW-1:0]              raddr_q;
  logic                       in_range_q;
  logic [ROW_BITS_W-1:0]      row_bits_q;

  // Box computation for a new draw request
  logic [RSW-1:0]             rs;
  logic signed [BW-1:0]       rs_e, cx_e, cy_e;
  logic [EW-1:0]              bx_d, ex_d, by_d, ey_d;
  logic [R2W-1:0]             r2_d;

  assign rs   = {radius_i, {FRAC_BITS{1'b0}}};
  assign rs_e = BW'(rs);
  assign cx_e = BW'(center_x_i);
  assign cy_e = BW'(center_y_i);
  assign r2_d = R2W'(rs) * R2W'(rs);

  always_comb begin
    span(cx_e, rs_e, LIM_X, bx_d, ex_d);
    span(cy_e, rs_e, LIM_Y, by_d, ey_d);
  end

  // Column offset and its square
  logic [PXW-1:0]             pix_x;
  logic signed [DXW-1:0]      dx;
  logic [MXW-1:0]             dx_mag;
  logic [2*MXW-1:0]           dx_sq;

  assign pix_x  = {col_q, 1'b1, {(FRAC_BITS-1){1'b0}}};
  assign dx     = DXW'(cx_q) - DXW'(pix_x);
  assign dx_mag = dx[DXW-1] ? MXW'(-dx) : MXW'(dx);
  assign dx_sq  = (2*MXW)'(dx_mag) * (2*MXW)'(dx_mag);

  // Row offset and its square
  logic [PYW-1:0]             pix_y;
  logic signed [DYW-1:0]      dy;
  logic [MYW-1:0]             dy_mag;
  logic [2*MYW-1:0]           dy_sq;

  assign pix_y  = {y_q[AW-1:0], 1'b1, {(FRAC_BITS-1){1'b0}}};
  assign dy     = DYW'(cy_q) - DYW'(pix_y);
  assign dy_mag = dy[DYW-1] ? MYW'(-dy) : MYW'(dy);
  assign dy_sq  = (2*MYW)'(dy_mag) * (2*MYW)'(dy_mag);

  // Status toward the controller
  always_comb begin
    status_o           = '0;
    status_o.col_last  = (col_q == CCW'(FRAME_WIDTH - 1));
    status_o.box_empty = empty_q;
    status_o.row_last  = ((y_q + YCW'(1)) == ey_q);
  end

  // Frame store
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [FRAME_WIDTH-1:0] ram_rdata;
  logic [FRAME_WIDTH-1:0] hit;
  logic [FRAME_WIDTH-1:0] wr_row;
  logic [FRAME_WIDTH-1:0] rd_row;
  logic [SW-1:0]          sel_ext;

  assign sel_ext   = SW'(row_select_i);
  assign ram_re    = cmd_i.read_row || cmd_i.row_step;
  assign ram_raddr = cmd_i.row_step ? y_q[AW-1:0] : sel_ext[AW-1:0];

  crf_ram #(
    .WIDTH (FRAME_WIDTH),
    .DEPTH (FRAME_HEIGHT)
  ) u_crf_ram (
    .clk_i   (clk_i),
    .we_i    (wr_pend_q),
    .waddr_i (y1_q),
    .wdata_i (wr_row),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Test every column of the current row against the radius
  always_comb begin
    for (int x = 0; x < FRAME_WIDTH; x++) begin
      hit[x] = mask_q[x] && ((SUMW'(dx2_q[x]) + SUMW'(dy2_q)) <= SUMW'(r2_q));
    end
  end

  // Merge the hits into the stored row; unwritten rows read as background
  assign wr_row = (row_valid_q[y1_q] ? ram_rdata : '0) | hit;
  assign rd_row = (in_range_q && row_valid_q[raddr_q]) ? ram_rdata : '0;

  // Capture draw and read requests, step the column and row passes
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q    <= center_x_i;
      cy_q    <= center_y_i;
      r2_q    <= r2_d;
      bx_q    <= bx_d;
      ex_q    <= ex_d;
      ey_q    <= YCW'(ey_d);
      empty_q <= (by_d >= ey_d) || (bx_d >= ex_d);
      col_q   <= '0;
      y_q     <= YCW'(by_d);
    end
    if (cmd_i.col_step) begin
      dx2_q[col_q]  <= dx_sq;
      mask_q[col_q] <= (EW'(col_q) >= bx_q) && (EW'(col_q) < ex_q);
      col_q         <= col_q + CCW'(1);
    end
    if (cmd_i.row_step) begin
      dy2_q <= dy_sq;
      y1_q  <= y_q[AW-1:0];
      y_q   <= y_q + YCW'(1);
    end
    if (cmd_i.read_row) begin
      raddr_q    <= sel_ext[AW-1:0];
      in_range_q <= (sel_ext < SW'(FRAME_HEIGHT));
    end
    if (cmd_i.out_load) begin
      row_bits_q <= ROW_BITS_W'(rd_row);
    end
  end

  // Track written rows; clear and reset blank the frame at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q   <= 1'b0;
      row_valid_q <= '0;
    end else begin
      wr_pend_q <= cmd_i.row_step;
      if (cmd_i.clear) begin
        row_valid_q <= '0;
      end else if (wr_pend_q) begin
        row_valid_q[y1_q] <= 1'b1;
      end
    end
  end

  assign row_bits_o = row_bits_q;

endmodule

`default_nettype wire

[rtl/circle_raster_framebuffer_core.sv]
// Top level of the filled-circle rasterizer over a one-bit frame buffer.
// A request is taken when start is high and busy is low. Clear blanks the
// frame in the cycle it is taken and never raises busy. Read raises busy for
// one cycle, then strobes done_o with the registered row from the store;
// the receiver cannot stall, so row_bits_o is valid only while done_o is
// high. Draw holds busy through a column pass, a row pass over the clipped
// box (at most min(2 * radius, FRAME_HEIGHT) rows) and a drain state: the
// column pass squares one column offset per cycle through one multiplier,
// then the row pass reads, tests all columns in parallel and writes back one
// frame row per cycle through the store's read and write ports. A draw whose
// clipped box is empty holds busy for one cycle. Reset and clear take effect
// at once through per-row valid bits, so no clearing pass is needed.
`default_nettype none

module circle_raster_framebuffer_core #(
  parameter int FRAME_WIDTH  = 64,
  parameter int FRAME_HEIGHT = 32,
  parameter int FRAC_BITS    = 4
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [crf_pkg::ACTION_W-1:0]         action_i,
  input  wire logic signed [crf_pkg::CENTER_W-1:0]  center_x_i,
  input  wire logic signed [crf_pkg::CENTER_W-1:0]  center_y_i,
  input  wire logic [crf_pkg::RADIUS_W-1:0]         radius_i,
  input  wire logic [crf_pkg::ROW_SEL_W-1:0]        row_select_i,
  output logic                                      done_o,
  output logic [crf_pkg::ROW_BITS_W-1:0]            row_bits_o
);

  import crf_pkg::*;

  crf_cmd_t    cmd;
  crf_status_t status;

  // Sequence requests
  crf_ctrl u_crf_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (action_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  // Compute and store pixels
  crf_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .FRAC_BITS    (FRAC_BITS)
  ) u_crf_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .radius_i     (radius_i),
    .row_select_i (row_select_i),
    .status_o     (status),
    .row_bits_o   (row_bits_o)
  );

endmodule

`default_nettype wire

[rtl/crf_checker.sv]
// Port-level checks of the circle raster frame buffer, bound to the top level.
`default_nettype none

module crf_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic [crf_pkg::ACTION_W-1:0]       action_i,
  input wire logic                               done_o,
  input wire logic [crf_pkg::ROW_BITS_W-1:0]     row_bits_o
);

  import crf_pkg::*;

  logic take_read, take_clear;

  assign take_read  = start && !busy && (action_i == ACT_READ);
  assign take_clear = start && !busy && (action_i == ACT_CLEAR);

  // A read request is always followed by its result strobe
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_read |-> ##2 done_o)
    else $error("read request gave no result");

  // A result follows a busy cycle
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a preceding read");

  // Results never come back to back
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // Clear does not stall the port
  a_clear_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_clear |=> !busy)
    else $error("clear raised busy");

  // A row read right after a clear is background
  a_clear_then_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_clear ##1 take_read |-> ##2 (row_bits_o == '0))
    else $error("row not blank after clear");

endmodule

bind circle_raster_framebuffer_core crf_checker u_crf_checker (.*);

`default_nettype wire

[tb/sv/tb.sv]
// Testbench for circle_raster_framebuffer_core: directed table plus random requests.
`timescale 1ns / 100ps

module tb;
  import crf_pkg::*;

  // Fixed geometry of the instance under test
  localparam int FRAC       = 4;
  localparam int SCALE      = 1 << FRAC;
  localparam int HALF       = SCALE / 2;
  localparam int FW         = 64;
  localparam int FH         = 32;
  localparam int NUM_RANDOM = 950;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYC  = 120;

  // The fourth action code is not in the package enum
  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

  typedef struct {
    logic [ACTION_W-1:0]         act;
    logic signed [CENTER_W-1:0]  cx;
    logic signed [CENTER_W-1:0]  cy;
    logic [RADIUS_W-1:0]         rad;
    logic [ROW_SEL_W-1:0]        sel;
    bit                          has_known;
    logic [ROW_BITS_W-1:0]       known;
  } req_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    done_o;
  logic [ROW_BITS_W-1:0]   row_bits_o;
  req_t                    drv_req = '{ACT_NONE, '0, '0, '0, '0, 1'b0, '0};

  // Predicted frame contents and rows still owed by the block
  logic [FW-1:0]           frame_model [FH];
  logic [ROW_BITS_W-1:0]   row_expect_q [$];
  logic [ROW_BITS_W-1:0]   row_expected;
  req_t                    plan_q [$];

  int n_draw = 0, n_read = 0, n_clear = 0, n_nop = 0;
  int n_checked = 0, n_err = 0, idle_cycles = 0;
  int burst_left = 0;

  circle_raster_framebuffer_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (drv_req.act),
    .center_x_i   (drv_req.cx),
    .center_y_i   (drv_req.cy),
    .radius_i     (drv_req.rad),
    .row_select_i (drv_req.sel),
    .done_o       (done_o),
    .row_bits_o   (row_bits_o)
  );

  // Free-running clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Clipped, end-exclusive pixel span of one axis
  function automatic void disc_span(input int c, input int rs, input int lim,
                                    output int b, output int e);
    int lo, hi;
    lo = c - rs;
    hi = c + rs;
    if (lo < 0) lo = 0;
    if (hi > lim * SCALE) hi = lim * SCALE;
    b = lo / SCALE;
    e = (hi > 0) ? hi / SCALE : 0;
  endfunction

  // Mark every pixel of the box whose center lies within the radius
  function automatic void paint_disc(input int cx, input int cy, input int rad);
    int rs, r2, bx, ex, by, ey, dx, dy;
    rs = rad * SCALE;
    r2 = rs * rs;
    disc_span(cx, rs, FW, bx, ex);
    disc_span(cy, rs, FH, by, ey);
    for (int y = by; y < ey; y++) begin
      dy = cy - (y * SCALE + HALF);
      for (int x = bx; x < ex; x++) begin
        dx = cx - (x * SCALE + HALF);
        if (dx * dx + dy * dy <= r2) frame_model[y][x] = 1'b1;
      end
    end
  endfunction

  // Advance the frame model by one accepted request
  function automatic void apply_request(input req_t rq);
    case (rq.act)
      ACT_CLEAR: begin
        foreach (frame_model[i]) frame_model[i] = '0;
        n_clear++;
      end
      ACT_DRAW: begin
        paint_disc(int'(rq.cx), int'(rq.cy), int'(rq.rad));
        n_draw++;
      end
      ACT_READ: begin
        if (rq.has_known) row_expect_q.push_back(rq.known);
        else if (rq.sel < FH) row_expect_q.push_back(frame_model[rq.sel]);
        else row_expect_q.push_back('0);
        n_read++;
      end
      default: n_nop++;
    endcase
  endfunction

  function automatic void plan(input logic [ACTION_W-1:0] act, input int cx, input int cy,
                               input int rad, input int sel, input bit has_known,
                               input logic [ROW_BITS_W-1:0] known);
    req_t rq;
    rq.act       = act;
    rq.cx        = CENTER_W'(cx);
    rq.cy        = CENTER_W'(cy);
    rq.rad       = RADIUS_W'(rad);
    rq.sel       = ROW_SEL_W'(sel);
    rq.has_known = has_known;
    rq.known     = known;
    plan_q.push_back(rq);
  endfunction

  // Build one random request, mostly small discs near the frame
  function automatic req_t random_request();
    req_t rq;
    int pick;
    pick         = $urandom_range(0, 99);
    rq.cx        = CENTER_W'($urandom);
    rq.cy        = CENTER_W'($urandom);
    rq.rad       = RADIUS_W'($urandom);
    rq.sel       = ROW_SEL_W'($urandom);
    rq.has_known = 1'b0;
    rq.known     = '0;
    if (pick < 3) rq.act = ACT_CLEAR;
    else if (pick < 6) rq.act = ACT_NONE;
    else if (pick < 50) rq.act = ACT_READ;
    else begin
      rq.act = ACT_DRAW;
      if ($urandom_range(0, 4) != 0) begin
        rq.cx  = CENTER_W'(int'($urandom_range(0, 1279)) - 128);
        rq.cy  = CENTER_W'(int'($urandom_range(0, 767)) - 128);
        rq.rad = ($urandom_range(0, 7) == 0) ? RADIUS_W'($urandom_range(0, 31))
                                             : RADIUS_W'($urandom_range(0, 8));
      end
    end
    return rq;
  endfunction

  // Present one request and hold it until the block takes it
  task automatic issue(input req_t rq);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 10);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 200)
                                              : $urandom_range(1, 30);
      @(negedge clk_i);
      start <= 1'b0;
      drv_req <= random_request();
      repeat (gap - 1) @(negedge clk_i);
    end
    burst_left--;
    @(negedge clk_i);
    drv_req <= rq;
    start   <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // Check returned rows, track accepted requests and the idle count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (row_expect_q.size() == 0) begin
          n_err++;
          $display("%0t: row result with none expected, actual %h", $time, row_bits_o);
        end else begin
          row_expected = row_expect_q.pop_front();
          n_checked++;
          if (row_bits_o !== row_expected) begin
            n_err++;
            $display("%0t: row_bits mismatch, expected %h actual %h",
                     $time, row_expected, row_bits_o);
          end
        end
      end
      if (start && busy === 1'b0) apply_request(drv_req);
      if ((start && busy === 1'b0) || done_o === 1'b1) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("circle_raster_framebuffer_core verification failed");
    $finish;
  end

  initial begin : stimulus
    foreach (frame_model[i]) frame_model[i] = '0;

    // Directed table: reset state, unused code, zero radius, clipping, clear
    plan(ACT_READ,     0,     0,  0,  0, 1'b1, 64'h0);
    plan(ACT_READ,     0,     0,  0, 31, 1'b1, 64'h0);
    plan(ACT_NONE,   512,   256,  5, 16, 1'b0, 64'h0);
    plan(ACT_DRAW,   512,   256,  0,  0, 1'b0, 64'h0);
    plan(ACT_READ,     0,     0,  0, 16, 1'b1, 64'h0);
    plan(ACT_DRAW,    88,    56,  1,  0, 1'b0, 64'h0);
    plan(ACT_READ,     0,     0,  0,  2, 1'b1, 64'h20);
    plan(ACT_READ,     0,     0,  0,  3, 1'b1, 64'h30);
    plan(ACT_READ,     0,     0,  0,  4, 1'b1, 64'h0);
    plan(ACT_DRAW, -2048, -2048, 31,  0, 1'b0, 64'h0);
    plan(ACT_DRAW,  2047,  2047, 31,  0, 1'b0, 64'h0);
    plan(ACT_DRAW, -2048,  2047, 31,  0, 1'b0, 64'h0);
    plan(ACT_DRAW,    -8,    -8,  1,  0, 1'b0, 64'h0);
    plan(ACT_DRAW,   -24,   -24,  1,  0, 1'b0, 64'h0);
    plan(ACT_READ,     0,     0,  0,  0, 1'b1, 64'h0);
    plan(ACT_DRAW,  1023,   511, 31,  0, 1'b0, 64'h0);
    plan(ACT_READ,     0,     0,  0, 31, 1'b0, 64'h0);
    plan(ACT_READ,     0,     0,  0,  0, 1'b0, 64'h0);
    plan(ACT_CLEAR,    0,     0,  0,  0, 1'b0, 64'h0);
    plan(ACT_READ,     0,     0,  0, 31, 1'b1, 64'h0);
    plan(ACT_DRAW,   512,   256, 31,  0, 1'b0, 64'h0);
    plan(ACT_READ,     0,     0,  0, 16, 1'b0, 64'h0);
    plan(ACT_READ,     0,     0,  0,  0, 1'b0, 64'h0);
    plan(ACT_CLEAR,    0,     0,  0,  0, 1'b0, 64'h0);
    plan(ACT_READ,     0,     0,  0,  5, 1'b1, 64'h0);

    // Hold reset, then release it on a falling edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan_q[i]) issue(plan_q[i]);
    repeat (NUM_RANDOM) issue(random_request());

    // Drop start, drain the owed rows, then let any draw finish
    @(negedge clk_i);
    start <= 1'b0;
    while (row_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Run covered %0d draws, %0d reads, %0d clears and %0d ignored requests",
             n_draw, n_read, n_clear, n_nop);
    $display("Compared %0d returned rows, %0d mismatches", n_checked, n_err);
    if (n_err == 0) begin
      $display("circle_raster_framebuffer_core verification clean");
    end else begin
      $display("circle_raster_framebuffer_core verification failed");
    end
    $finish;
  end

endmodule
